// ----- rtl/core/lkv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef logic        [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t MISS_VALUE = -32'sd1;
  localparam val_t PUT_VALUE  = 32'sd0;

  // operation codes of the func field
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  typedef struct packed {
    logic valid;
    key_t key;
    val_t value;
  } entry_t;

  typedef struct packed {
    logic cmp_en;
    logic take;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/lkv_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lkv_req_if;
  logic          valid;
  logic          ready;
  logic          func;
  lkv_pkg::key_t lookup_key;
  lkv_pkg::val_t put_value;

  modport source (output valid, output func, output lookup_key, output put_value,
                  input ready);
  modport sink   (input valid, input func, input lookup_key, input put_value,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lkv_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lkv_rsp_if;
  logic          valid;
  logic          ready;
  lkv_pkg::val_t read_value;
  logic          hit;
  logic          evicted;

  modport source (output valid, output read_value, output hit, output evicted,
                  input ready);
  modport sink   (input valid, input read_value, input hit, input evicted,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lkv_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lkv_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire lkv_pkg::cell_ctrl_t ctrl_i,
  input  wire lkv_pkg::key_t       cmp_key_i,
  input  wire lkv_pkg::entry_t     prev_i,
  output lkv_pkg::entry_t          entry_o,
  output logic                     match_o
);
  import lkv_pkg::*;

  logic valid_q;
  key_t key_q;
  val_t value_q;
  logic match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctrl_i.take) begin
        valid_q <= prev_i.valid;
      end
      if (ctrl_i.cmp_en) begin
        match_q <= valid_q && (key_q == cmp_key_i);
      end
    end
  end

  // take the neighbor's entry: the row shifts one place toward older
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      key_q   <= prev_i.key;
      value_q <= prev_i.value;
    end
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;
  assign match_o       = match_q;

endmodule

`default_nettype wire

// ----- rtl/core/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement, built
// as a row of ENTRIES cells ordered by recency: cell 0 holds the most recent
// entry and the valid entries always fill cells 0 to count-1. An item passes a
// compare state, where every cell compares the key, and an update state, where,
// for a put or a hit, the hit cell, the first free cell or the oldest cell is
// picked and the cells ahead of it shift one place while the new or touched
// entry enters cell 0. A new item is taken in the update cycle of the previous
// one; a result waiting in the output register holds the update cycle only.
// Entries are cleared at reset at once, with no clearing pass. Capacity is to
// be written only while no item is in flight; the block does not enforce this.
// Zero acts as one, values above ENTRIES as ENTRIES; lowering it drops no entry.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [lkv_pkg::CAP_W-1:0]      cfg_wdata_i,
  lkv_req_if.sink                       req_i,
  lkv_rsp_if.source                     rsp_o
);
  import lkv_pkg::*;

  localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  state_e st_q, st_d;

  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    used_q, used_d;
  logic             func_q;
  key_t             key_q;
  val_t             val_q;

  logic             rsp_valid_q, rsp_valid_d;
  val_t             rd_q;
  logic             hit_q;
  logic             ev_q;

  entry_t             ent  [ENTRIES];
  cell_ctrl_t         ctrl [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;
  entry_t             head;

  logic          out_free;
  logic          accept;
  logic          go;
  logic          hit;
  logic [IW-1:0] hit_idx;
  val_t          found_val;
  logic [CMPW-1:0] cap_wide;
  logic [CW-1:0] eff_cap;
  logic          fill;
  logic [CW-1:0] tgt;
  logic          upd;

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (st_q == S_IDLE) || ((st_q == S_UPD) && out_free);
  assign accept      = req_i.valid && req_i.ready;
  assign go          = (st_q == S_UPD) && out_free;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (accept) st_d = S_CMP;
      S_CMP:  st_d = S_UPD;
      S_UPD: begin
        if (go) st_d = accept ? S_CMP : S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  // one-hot match, so an OR over the row selects index and value
  always_comb begin
    hit_idx   = '0;
    found_val = '0;
    for (int i = 0; i < int'(ENTRIES); i++) begin
      if (match_vec[i]) hit_idx = hit_idx | IW'(i);
      found_val = found_val | (ent[i].value & {VAL_W{match_vec[i]}});
    end
  end

  assign hit = |match_vec;

  always_comb begin
    cap_wide = CMPW'(cap_q);
    if (cap_wide == '0) begin
      eff_cap = CW'(1);
    end else if (cap_wide > CMPW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = CW'(cap_wide);
    end
  end

  assign fill = !hit && (used_q < eff_cap);

  // last cell that shifts: the hit cell, the first free cell, or the oldest
  always_comb begin
    if (hit) begin
      tgt = CW'(hit_idx);
    end else if (fill) begin
      tgt = used_q;
    end else begin
      tgt = used_q - CW'(1);
    end
  end

  assign upd = go && ((func_q == FUNC_PUT) || hit);

  assign head.valid = 1'b1;
  assign head.key   = key_q;
  assign head.value = (func_q == FUNC_PUT) ? val_q : found_val;

  assign used_d = (go && (func_q == FUNC_PUT) && fill) ? used_q + CW'(1) : used_q;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (go) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  for (genvar g = 0; g < int'(ENTRIES); g++) begin : g_cell
    assign ctrl[g].cmp_en = (st_q == S_CMP);
    assign ctrl[g].take   = upd && (CW'(g) <= tgt);
    assign valid_vec[g]   = ent[g].valid;

    if (g == 0) begin : g_head
      lkv_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl[g]),
        .cmp_key_i (key_q),
        .prev_i    (head),
        .entry_o   (ent[g]),
        .match_o   (match_vec[g])
      );
    end else begin : g_body
      lkv_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl[g]),
        .cmp_key_i (key_q),
        .prev_i    (ent[g-1]),
        .entry_o   (ent[g]),
        .match_o   (match_vec[g])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cap_q       <= CAP_RESET;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      used_q      <= used_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      key_q  <= req_i.lookup_key;
      val_q  <= req_i.put_value;
    end
    if (go) begin
      hit_q <= hit;
      ev_q  <= (func_q == FUNC_PUT) && !hit && !fill;
      if (func_q == FUNC_PUT) begin
        rd_q <= PUT_VALUE;
      end else begin
        rd_q <= hit ? found_val : MISS_VALUE;
      end
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_value = rd_q;
  assign rsp_o.hit        = hit_q;
  assign rsp_o.evicted    = ev_q;

`ifndef SYNTHESIS
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & ENTRIES'(valid_vec + 1'b1)) == '0)
    else $error("valid cells are not a prefix of the row");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(used_q))
    else $error("entry count disagrees with valid cells");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_UPD) |-> $onehot0(match_vec))
    else $error("key matches more than one cell");

  a_result_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> rsp_valid_q)
    else $error("update did not load a result");

  a_evict_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && (func_q == FUNC_PUT) && !hit && !fill) |-> (used_q != '0))
    else $error("eviction from an empty row");
`endif

endmodule

`default_nettype wire
